// ----- src/wqps_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted quota path scheduler package
// Shared widths, status codes and the structs passed between the scheduler
// modules.
// ----------------------------------------------------------------------------
package wqps_pkg;

	localparam int NUM_PATHS = 8;
	localparam int IDX_W     = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int CNT_W     = $clog2(NUM_PATHS + 1);
	localparam int LEN_W     = 16;
	localparam int DIV_CNT_W = $clog2(LEN_W + 1);
	localparam int INC_W     = LEN_W + 1;
	localparam int SUM_W     = LEN_W + 2;
	localparam int BYTE_W    = 8;
	localparam int VEC_W     = NUM_PATHS * BYTE_W;
	localparam int LIMIT_W   = 24;
	localparam int PATH_W    = 3;

	typedef enum logic [1:0] {
		STATUS_SENT = 2'd0,
		STATUS_WAIT = 2'd1,
		STATUS_NONE = 2'd2
	} status_t;

	typedef struct packed {
		logic              ok;
		logic [1:0]        rank;
		logic [BYTE_W-1:0] split;
		logic              full;
	} rank_res_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] quo;
		logic             rem_nz;
	} div_res_t;

endpackage

// ----- src/wqps_rank.sv -----
// ----------------------------------------------------------------------------
// Path ranking unit
// Classifies one path from its weight, quota and free window; shared by all
// paths over the scan.
// ----------------------------------------------------------------------------
module wqps_rank (
	input  logic [wqps_pkg::BYTE_W-1:0] weight,
	input  logic [wqps_pkg::BYTE_W-1:0] quota,
	input  logic [wqps_pkg::BYTE_W-1:0] space,
	output wqps_pkg::rank_res_t         res
);
	import wqps_pkg::*;

	logic partly;
	logic unused;
	logic [BYTE_W-1:0] split;

	assign partly = (quota != '0) && (quota < weight);
	assign unused = (quota == '0) && (weight != '0);
	assign split  = partly ? (weight - quota) : weight;

	always_comb begin
		res.ok    = partly || unused;
		res.split = split;
		res.full  = (quota >= weight);
		if (partly) begin
			res.rank = (split > space) ? 2'd0 : 2'd1;
		end else begin
			res.rank = (split > space) ? 2'd2 : 2'd3;
		end
	end

endmodule

// ----- src/wqps_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, with a flag for a nonzero
// remainder so that the caller can round up.
// ----------------------------------------------------------------------------
module wqps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wqps_pkg::LEN_W-1:0] dividend,
	input  logic [wqps_pkg::LEN_W-1:0] divisor,
	output wqps_pkg::div_res_t         res
);
	import wqps_pkg::*;

	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     quo_q;
	logic [LEN_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [LEN_W:0]       trial;
	logic                 take;

	assign trial = {rem_q, quo_q[LEN_W-1]};
	assign take  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(LEN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= LEN_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[LEN_W-1:0];
			end
			quo_q <= {quo_q[LEN_W-2:0], take};
		end
	end

	assign res.done   = done_q;
	assign res.quo    = quo_q;
	assign res.rem_nz = (rem_q != '0);

endmodule

// ----- src/weighted_quota_path_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Weighted quota path scheduler
// Picks one path per segment request by rank, weight and running quota.
// ----------------------------------------------------------------------------
// The request arrives on the s_ group and one result leaves on the m_ group
// for every request. The weights register is written on the cfg_ channel,
// which is always ready; it must only be written while no request is open.
// A request is scanned one path per cycle through a single ranking unit.
// When every considered path is full, the quotas of the paths not down are
// cleared and the paths are scanned once more. A segment longer than the MSS
// then runs through a bit-serial divider to get the quota increment.
// The block takes one request at a time and is ready again once its result
// sits in the output register. If the receiver stalls, the result is held
// and the next request is still taken and worked on; that one then waits
// for the output register to free up. Reset clears all quotas, restores the
// weights to one for every path and empties the output register.
// ----------------------------------------------------------------------------
module weighted_quota_path_scheduler_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// seg_len[15:0], mss[31:16], down_mask[39:32], busy_mask[47:40],
	// window_vec[111:48]
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], chosen_path[4:2], byte_limit[28:5], zero fill above
	output logic [31:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [63:0]  cfg_data
);
	import wqps_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t               state_q;
	logic [VEC_W-1:0]     weights_q;
	logic [BYTE_W-1:0]    quota_q [NUM_PATHS];
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     mss_q;
	logic [NUM_PATHS-1:0] down_q;
	logic [NUM_PATHS-1:0] busy_q;
	logic [VEC_W-1:0]     win_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cons_q;
	logic [CNT_W-1:0]     full_q;
	logic                 best_valid_q;
	logic [1:0]           best_rank_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [BYTE_W-1:0]    best_split_q;
	logic [BYTE_W-1:0]    best_quota_q;
	logic                 rescan_q;
	logic [INC_W-1:0]     inc_q;
	status_t              res_status_q;
	logic [PATH_W-1:0]    res_path_q;
	logic [LIMIT_W-1:0]   res_limit_q;
	logic                 m_tvalid_q;
	logic [31:0]          m_tdata_q;

	logic [BYTE_W-1:0]    cur_weight;
	logic [BYTE_W-1:0]    cur_quota;
	logic [BYTE_W-1:0]    cur_space;
	rank_res_t            rr;
	div_res_t             dr;
	logic                 div_start;
	logic                 clear_cond;
	logic                 last_idx;
	logic [SUM_W-1:0]     quota_sum;
	logic [LEN_W-1:0]     mss_in;

	assign cur_weight = weights_q[{idx_q, 3'b000} +: BYTE_W];
	assign cur_quota  = quota_q[idx_q];
	assign cur_space  = win_q[{idx_q, 3'b000} +: BYTE_W];
	assign last_idx   = (idx_q == IDX_W'(NUM_PATHS - 1));
	assign clear_cond = !best_valid_q && (cons_q != '0) && (cons_q == full_q) && !rescan_q;
	assign div_start  = (state_q == ST_DECIDE) && !clear_cond && best_valid_q && (len_q > mss_q);
	assign quota_sum  = SUM_W'(best_quota_q) + SUM_W'(inc_q);
	assign mss_in     = (s_tdata[31:16] == '0) ? LEN_W'(1) : s_tdata[31:16];

	wqps_rank u_rank (
		.weight (cur_weight),
		.quota  (cur_quota),
		.space  (cur_space),
		.res    (rr)
	);

	wqps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (len_q),
		.divisor  (mss_q),
		.res      (dr)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			weights_q    <= {NUM_PATHS{8'h01}};
			for (int i = 0; i < NUM_PATHS; i++) begin
				quota_q[i] <= '0;
			end
			idx_q        <= '0;
			cons_q       <= '0;
			full_q       <= '0;
			best_valid_q <= 1'b0;
			rescan_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				weights_q <= cfg_data[VEC_W-1:0];
			end
			if ((state_q == ST_OUT) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q        <= '0;
						cons_q       <= '0;
						full_q       <= '0;
						best_valid_q <= 1'b0;
						rescan_q     <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!down_q[idx_q]) begin
						cons_q <= cons_q + 1'b1;
						if (!busy_q[idx_q]) begin
							if (rr.ok && (!best_valid_q || (rr.rank < best_rank_q))) begin
								best_valid_q <= 1'b1;
							end
							if (rr.full) begin
								full_q <= full_q + 1'b1;
							end
						end
					end
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (clear_cond) begin
						for (int i = 0; i < NUM_PATHS; i++) begin
							if (!down_q[i]) begin
								quota_q[i] <= '0;
							end
						end
						idx_q        <= '0;
						cons_q       <= '0;
						full_q       <= '0;
						best_valid_q <= 1'b0;
						rescan_q     <= 1'b1;
						state_q      <= ST_SCAN;
					end else if (best_valid_q) begin
						state_q <= (len_q > mss_q) ? ST_DIV : ST_UPDATE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (dr.done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (quota_sum > SUM_W'(255)) begin
						quota_q[best_idx_q] <= 8'hff;
					end else begin
						quota_q[best_idx_q] <= quota_sum[BYTE_W-1:0];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				len_q  <= s_tdata[15:0];
				mss_q  <= mss_in;
				down_q <= s_tdata[32 +: NUM_PATHS];
				busy_q <= s_tdata[40 +: NUM_PATHS];
				win_q  <= s_tdata[48 +: VEC_W];
			end
			ST_SCAN: begin
				if (!down_q[idx_q] && !busy_q[idx_q] && rr.ok &&
				    (!best_valid_q || (rr.rank < best_rank_q))) begin
					best_rank_q  <= rr.rank;
					best_idx_q   <= idx_q;
					best_split_q <= rr.split;
					best_quota_q <= cur_quota;
				end
			end
			ST_DECIDE: begin
				inc_q        <= INC_W'(1);
				res_status_q <= (cons_q > full_q) ? STATUS_WAIT : STATUS_NONE;
				res_path_q   <= '0;
				res_limit_q  <= '0;
			end
			ST_DIV: begin
				if (dr.done) begin
					inc_q <= INC_W'(dr.quo) + INC_W'(dr.rem_nz);
				end
			end
			ST_UPDATE: begin
				res_status_q <= STATUS_SENT;
				res_path_q   <= PATH_W'(best_idx_q);
				res_limit_q  <= LIMIT_W'(best_split_q) * LIMIT_W'(mss_q);
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {3'b000, res_limit_q, res_path_q, res_status_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
